### src/lks_pkg.sv
// Package with shared types, constants and command/status structs for the keepalive scheduler.
`timescale 1ns / 1ps
`default_nettype none
package lks_pkg;

  localparam int unsigned RateWindowMsDefault = 1000;
  localparam int unsigned FpsW = 23;
  localparam logic [9:0] FrameScale = 10'd1000;

  localparam logic [1:0] LinkInit = 2'd0;
  localparam logic [1:0] LinkDown = 2'd1;
  localparam logic [1:0] LinkUp   = 2'd2;

  localparam logic [2:0] RegStart   = 3'd0;
  localparam logic [2:0] RegTimeout = 3'd1;
  localparam logic [2:0] RegPing    = 3'd2;
  localparam logic [2:0] RegTelem   = 3'd3;
  localparam logic [2:0] RegResend  = 3'd4;
  localparam logic [2:0] RegScanEn  = 3'd5;
  localparam logic [2:0] RegScanPer = 3'd6;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        pong_received;
    logic [31:0] pong_echo_time;
  } in_item_t;

  typedef struct packed {
    logic            hello_req;
    logic            run_registration;
    logic            send_ping;
    logic            flush_telemetry;
    logic            run_scan;
    logic [1:0]      link_state;
    logic [31:0]     reconnects;
    logic [31:0]     frame_cnt;
    logic [FpsW-1:0] tx_fps;
    logic [31:0]     up_time_ms;
  } out_item_t;

  typedef struct packed {
    logic        hello_on_boot;
    logic [15:0] link_tmo_ms;
    logic [15:0] ping_ivl_ms;
    logic [15:0] telem_ivl_ms;
    logic [15:0] resend_period_ms;
    logic        scan_enabled;
    logic [15:0] scan_period_ms;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the item and run the timer update
    logic div_start; // start the rate division
    logic div_step;  // one restoring division step
    logic div_done;  // commit the quotient
    logic emit;      // latch the result item
  } cmd_t;

  typedef struct packed {
    logic need_div;  // this tick closes a rate window
    logic div_last;  // final division step
  } sts_t;

endpackage
`default_nettype wire

### src/link_keepalive_scheduler_core.sv
// Top level of the link keepalive scheduler: config port, controller and datapath.
// A result is registered through the Idle, Dec and Out controller states, with Div and
// Fin between them when the tick closes a rate window, for the 32-step bit-serial divider.
// One item at a time: the next item is taken only once the result is latched, after any output stall.
// Reset (rst_ni low, asynchronous) clears the link state, timers and frame and reconnect
// counters and restores the configuration registers to their documented defaults.
`timescale 1ns / 1ps
`default_nettype none
module link_keepalive_scheduler_core #(
  parameter int unsigned RateWindowMs = lks_pkg::RateWindowMsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire lks_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lks_pkg::out_item_t     out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  lks_pkg::cfg_t cfg;
  lks_pkg::cmd_t cmd;
  lks_pkg::sts_t sts;

  // Register file; software must write it only while no item is in flight; the block does not enforce this.
  lks_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // The controller holds the input stalled from acceptance until the result is latched.
  lks_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // The datapath works one tick's timers in a single update, then divides serially when a rate window closes.
  lks_datapath #(.RateWindowMs(RateWindowMs)) u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .out_o(out_data_o)
  );

endmodule
`default_nettype wire

### src/lks_datapath.sv
// Datapath: timers, counters, link state and a bit-serial divider for the frame rate.
`timescale 1ns / 1ps
`default_nettype none
module lks_datapath #(
  parameter int unsigned RateWindowMs = lks_pkg::RateWindowMsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lks_pkg::cfg_t     cfg_i,
  input  wire lks_pkg::in_item_t in_i,
  input  wire lks_pkg::cmd_t     cmd_i,
  output lks_pkg::sts_t          sts_o,
  output lks_pkg::out_item_t     out_o
);

  logic        started_q, seen_q, ever_up_q;
  logic [1:0]  link_q;
  logic [31:0] start_q, ping_t_q, flush_t_q, pong_t_q, replay_t_q, scan_t_q;
  logic [31:0] win_start_q, win_base_q, echo_q, frames_q, reconn_q;
  logic [22:0] rate_q;
  logic [4:0]  strobe_q;
  logic        need_div_q;
  logic [31:0] dividend_q, divisor_q, quot_q;
  logic [31:0] rem_q;
  logic [4:0]  bit_q;

  // Combinational per-tick update, mirroring the ordered checks of one tick.
  logic        st_d, seen_d, eu_d, hello, reg_s, ping, flush, scan;
  logic [1:0]  link_d;
  logic [31:0] now, sta_d, pi_d, fl_d, po_d, rp_d, sc_d, ws_d, wb_d, ec_d, fr_d, rc_d, win;

  always_comb begin
    now = in_i.now_ms;
    st_d = started_q; seen_d = seen_q; eu_d = ever_up_q; link_d = link_q;
    sta_d = start_q; pi_d = ping_t_q; fl_d = flush_t_q; po_d = pong_t_q;
    rp_d = replay_t_q; sc_d = scan_t_q; ws_d = win_start_q; wb_d = win_base_q;
    ec_d = echo_q; fr_d = frames_q; rc_d = reconn_q;
    hello = 1'b0; reg_s = 1'b0; ping = 1'b0; flush = 1'b0; scan = 1'b0;
    if (!started_q) begin
      st_d = 1'b1; sta_d = now; fl_d = now; pi_d = now; po_d = now; ws_d = now;
      wb_d = frames_q; rp_d = now; sc_d = now;
      if (cfg_i.hello_on_boot) begin
        hello = 1'b1; reg_s = 1'b1; fr_d = fr_d + 32'd1;
      end
      link_d = lks_pkg::LinkDown;
    end
    if (in_i.pong_received && (!seen_q || in_i.pong_echo_time != echo_q)) begin
      seen_d = 1'b1; ec_d = in_i.pong_echo_time; po_d = now;
      if (link_d != lks_pkg::LinkUp) begin
        if (ever_up_q) begin
          rc_d = rc_d + 32'd1; hello = 1'b1; reg_s = 1'b1;
          fr_d = fr_d + 32'd1; rp_d = now;
        end
        eu_d = 1'b1; link_d = lks_pkg::LinkUp;
      end
    end
    if (link_d == lks_pkg::LinkUp && (now - po_d) >= {16'd0, cfg_i.link_tmo_ms})
      link_d = lks_pkg::LinkDown;
    if ((now - pi_d) >= {16'd0, cfg_i.ping_ivl_ms}) begin
      ping = 1'b1; pi_d = now; fr_d = fr_d + 32'd1;
    end
    if ((now - fl_d) >= {16'd0, cfg_i.telem_ivl_ms}) begin
      flush = 1'b1; fl_d = now; fr_d = fr_d + 32'd1;
    end
    if (link_d == lks_pkg::LinkUp && cfg_i.resend_period_ms != 16'd0 &&
        (now - rp_d) >= {16'd0, cfg_i.resend_period_ms}) begin
      reg_s = 1'b1; fr_d = fr_d + 32'd1; rp_d = now;
    end
    if (cfg_i.scan_enabled && cfg_i.scan_period_ms != 16'd0 &&
        (now - sc_d) >= {16'd0, cfg_i.scan_period_ms}) begin
      scan = 1'b1; sc_d = now;
    end
    win = now - ws_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0; seen_q <= 1'b0; ever_up_q <= 1'b0; link_q <= lks_pkg::LinkInit;
      start_q <= '0; ping_t_q <= '0; flush_t_q <= '0; pong_t_q <= '0;
      replay_t_q <= '0; scan_t_q <= '0; win_start_q <= '0; win_base_q <= '0;
      echo_q <= '0; frames_q <= '0; reconn_q <= '0; rate_q <= '0;
      need_div_q <= 1'b0;
    end else if (cmd_i.load) begin
      started_q <= st_d; seen_q <= seen_d; ever_up_q <= eu_d; link_q <= link_d;
      start_q <= sta_d; ping_t_q <= pi_d; flush_t_q <= fl_d; pong_t_q <= po_d;
      replay_t_q <= rp_d; scan_t_q <= sc_d; echo_q <= ec_d; frames_q <= fr_d;
      reconn_q <= rc_d;
      need_div_q <= (win >= 32'(RateWindowMs)) && (win != 32'd0);
      if ((win >= 32'(RateWindowMs)) && (win != 32'd0)) begin
        win_start_q <= now; win_base_q <= fr_d;
      end else begin
        win_start_q <= ws_d; win_base_q <= wb_d;
      end
    end else if (cmd_i.div_done) begin
      rate_q <= quot_q[22:0];
    end
  end

  // Operands are captured with the tick; the window base is still the old one then.
  logic [31:0] delta;
  assign delta = fr_d - win_base_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      strobe_q   <= {hello, reg_s, ping, flush, scan};
      dividend_q <= 32'(delta * {22'd0, lks_pkg::FrameScale});
      divisor_q  <= win;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0; quot_q <= dividend_q; bit_q <= 5'd31;
    end else if (cmd_i.div_step) begin
      logic [32:0] sh;
      logic [32:0] diff;
      sh = {rem_q, quot_q[31]};
      diff = sh - {1'b0, divisor_q};
      if (sh >= {1'b0, divisor_q}) begin
        rem_q <= diff[31:0]; quot_q <= {quot_q[30:0], 1'b1};
      end else begin
        rem_q <= sh[31:0]; quot_q <= {quot_q[30:0], 1'b0};
      end
      bit_q <= bit_q - 5'd1;
    end
  end

  assign sts_o.need_div = need_div_q;
  assign sts_o.div_last = (bit_q == 5'd0);

  logic [31:0] latest;
  always_comb begin
    latest = ping_t_q;
    if (flush_t_q > latest) latest = flush_t_q;
    if (pong_t_q > latest) latest = pong_t_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_o.hello_req        <= strobe_q[4];
      out_o.run_registration <= strobe_q[3];
      out_o.send_ping        <= strobe_q[2];
      out_o.flush_telemetry  <= strobe_q[1];
      out_o.run_scan         <= strobe_q[0];
      out_o.link_state       <= link_q;
      out_o.reconnects       <= reconn_q;
      out_o.frame_cnt        <= frames_q;
      out_o.tx_fps           <= rate_q;
      out_o.up_time_ms       <= started_q ? latest - start_q : 32'd0;
    end
  end

endmodule
`default_nettype wire

### src/lks_ctrl.sv
// Controller state machine sequencing tick update, division and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module lks_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire lks_pkg::sts_t sts_i,
  output lks_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDec  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       emit_ok;

  assign emit_ok = !ovalid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o = '0;
    case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1; state_d = StDec;
      end
      StDec: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1; state_d = StDiv;
        end else state_d = StOut;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StFin;
      end
      StFin: begin
        cmd_o.div_done = 1'b1; state_d = StOut;
      end
      StOut: if (emit_ok) begin
        cmd_o.emit = 1'b1; ovalid_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d;
    end
  end

endmodule
`default_nettype wire

### src/lks_cfg.sv
// APB-style configuration register file.
`timescale 1ns / 1ps
`default_nettype none
module lks_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output lks_pkg::cfg_t    cfg_o
);

  logic [2:0] idx;
  assign idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_o.hello_on_boot    <= 1'b1;
      cfg_o.link_tmo_ms      <= 16'd1000;
      cfg_o.ping_ivl_ms      <= 16'd250;
      cfg_o.telem_ivl_ms     <= 16'd50;
      cfg_o.resend_period_ms <= 16'd0;
      cfg_o.scan_enabled     <= 1'b0;
      cfg_o.scan_period_ms   <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        lks_pkg::RegStart:   cfg_o.hello_on_boot    <= pwdata[0];
        lks_pkg::RegTimeout: cfg_o.link_tmo_ms      <= pwdata[15:0];
        lks_pkg::RegPing:    cfg_o.ping_ivl_ms      <= pwdata[15:0];
        lks_pkg::RegTelem:   cfg_o.telem_ivl_ms     <= pwdata[15:0];
        lks_pkg::RegResend:  cfg_o.resend_period_ms <= pwdata[15:0];
        lks_pkg::RegScanEn:  cfg_o.scan_enabled     <= pwdata[0];
        lks_pkg::RegScanPer: cfg_o.scan_period_ms   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lks_pkg::RegStart:   prdata = {31'd0, cfg_o.hello_on_boot};
      lks_pkg::RegTimeout: prdata = {16'd0, cfg_o.link_tmo_ms};
      lks_pkg::RegPing:    prdata = {16'd0, cfg_o.ping_ivl_ms};
      lks_pkg::RegTelem:   prdata = {16'd0, cfg_o.telem_ivl_ms};
      lks_pkg::RegResend:  prdata = {16'd0, cfg_o.resend_period_ms};
      lks_pkg::RegScanEn:  prdata = {31'd0, cfg_o.scan_enabled};
      lks_pkg::RegScanPer: prdata = {16'd0, cfg_o.scan_period_ms};
      default:             prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

### src/lks_checker.sv
// Port-level checker for the keepalive scheduler, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module lks_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire lks_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken during work");

  a_link_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.link_state != lks_pkg::LinkInit)
    else $error("result reports init link");

  a_hello_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hello_req |-> out_data_o.run_registration)
    else $error("hello without registration");

endmodule

bind link_keepalive_scheduler_core lks_checker u_lks_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
`default_nettype wire
